>>> src/ssd_pkg.sv
`default_nettype none
package ssd_pkg;

  // positions of the five dot products in the dot-product pipeline
  localparam int DOT_A = 0; // u.u
  localparam int DOT_B = 1; // u.v
  localparam int DOT_C = 2; // v.v
  localparam int DOT_D = 3; // u.w
  localparam int DOT_E = 4; // v.w
  localparam int DOT_N = 5;

  // quotient guard flags, settled before the divider
  typedef struct packed {
    logic zero; // quotient forced to 0
    logic one;  // quotient forced to exactly 1.0
  } ssd_qguard_t;

endpackage
`default_nettype wire

>>> src/ssd_mul.sv
`default_nettype none
// Signed multiplier split into four partial products; the partial products are registered, then their sum.
module ssd_mul #(
  parameter int AW = 52,
  parameter int BW = 52
) (
  input  wire logic                 clk,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);
  import ssd_pkg::*;

  localparam int HA = AW / 2;
  localparam int HB = BW / 2;
  localparam int PW = AW + BW;

  logic signed [HA+HB+1:0]     pll_r;
  logic signed [HA+BW-HB:0]    plh_r;
  logic signed [AW-HA+HB:0]    phl_r;
  logic signed [AW+BW-HA-HB-1:0] phh_r;

  logic signed [HA:0]      al;
  logic signed [HB:0]      bl;
  logic signed [AW-HA-1:0] ah;
  logic signed [BW-HB-1:0] bh;

  assign al = $signed({1'b0, a[HA-1:0]});
  assign bl = $signed({1'b0, b[HB-1:0]});
  assign ah = a[AW-1:HA];
  assign bh = b[BW-1:HB];

  always_ff @(posedge clk) begin
    pll_r <= al * bl;
    plh_r <= al * bh;
    phl_r <= ah * bl;
    phh_r <= ah * bh;
  end

  always_ff @(posedge clk) begin
    p <= (PW'(phh_r) <<< (HA + HB)) + (PW'(plh_r) <<< HB) + (PW'(phl_r) <<< HA)
         + PW'(pll_r);
  end

endmodule
`default_nettype wire

>>> src/ssd_div.sv
`default_nettype none
// Restoring divider, one quotient bit per stage: q = floor(num * 2^QB / den).
// Guard flags force the registered quotient to 0 or to 1.0.
module ssd_div #(
  parameter int NW = 105,
  parameter int QB = 24
) (
  input  wire logic                clk,
  input  wire logic [NW-1:0]       num,
  input  wire logic [NW-1:0]       den,
  input  wire ssd_pkg::ssd_qguard_t guard,
  output logic [QB:0]              quo
);
  import ssd_pkg::*;

  logic [NW-1:0] rem_r   [1:QB];
  logic [NW-1:0] den_r   [1:QB];
  logic [QB-1:0] q_r     [1:QB];
  ssd_qguard_t   guard_r [1:QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NW-1:0] src_rem;
    logic [NW-1:0] src_den;
    logic [QB-1:0] src_q;
    ssd_qguard_t   src_guard;
    logic [NW-1:0] shifted;
    logic          ge;

    if (k == 0) begin : g_first
      assign src_rem   = num;
      assign src_den   = den;
      assign src_q     = '0;
      assign src_guard = guard;
    end else begin : g_next
      assign src_rem   = rem_r[k];
      assign src_den   = den_r[k];
      assign src_q     = q_r[k];
      assign src_guard = guard_r[k];
    end

    // remainder stays below den, so the top bit is free for the shift
    assign shifted = {src_rem[NW-2:0], 1'b0};
    assign ge      = shifted >= src_den;

    always_ff @(posedge clk) begin
      rem_r[k+1]   <= ge ? shifted - src_den : shifted;
      den_r[k+1]   <= src_den;
      q_r[k+1]     <= {src_q[QB-2:0], ge};
      guard_r[k+1] <= src_guard;
    end
  end

  always_ff @(posedge clk) begin
    priority if (guard_r[QB].zero) begin
      quo <= '0;
    end else if (guard_r[QB].one) begin
      quo <= {1'b1, {QB{1'b0}}};
    end else begin
      quo <= {1'b0, q_r[QB]};
    end
  end

endmodule
`default_nettype wire

>>> src/segment_to_segment_distance_core.sv
`default_nettype none
// Channel      | Ports                                   | Transaction
// -------------+-----------------------------------------+-------------------------------
// input        | start, busy, in_{a,b}_{start,end}_{x,y,z} | start high while busy low
// result       | out_valid, out_gap_{x,y,z}              | one cycle strobe, no back-pressure
//
// Fully pipelined: one transaction per cycle.
// The depth is set by the restoring dividers for sc and tc, one quotient bit per stage.
// busy is never raised; the pipeline has no stall path, as results cannot be held off.
// Reset (synchronous, active low) clears only the valid bits; data registers are free.
module segment_to_segment_distance_core #(
  parameter int COORD_WIDTH    = 24,
  parameter int QUOT_FRAC_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_start_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_end_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_start_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_end_z,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH:0]        out_gap_x,
  output logic signed [COORD_WIDTH:0]        out_gap_y,
  output logic signed [COORD_WIDTH:0]        out_gap_z
);
  import ssd_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int QB  = QUOT_FRAC_BITS;
  localparam int PW  = 2 * CW + 2;      // one coordinate product
  localparam int EW  = 2 * CW + 4;      // dot product
  localparam int NW  = 4 * CW + 9;      // determinant and numerators
  localparam int MW  = CW + QB + 3;     // u * sc
  localparam int TW  = CW + QB + 4;     // unscaled gap
  localparam int UVW_LAST = QB + 10;    // stage at which the quotients appear
  localparam int LAT = QB + 13;

  // no stall path
  assign busy = 1'b0;

  // valid bits travel beside the data
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // ---- stage 1: direction and offset vectors u, v, w
  logic signed [CW-1:0] as_c [3];
  logic signed [CW-1:0] ae_c [3];
  logic signed [CW-1:0] bs_c [3];
  logic signed [CW-1:0] be_c [3];
  assign as_c[0] = in_a_start_x; assign as_c[1] = in_a_start_y; assign as_c[2] = in_a_start_z;
  assign ae_c[0] = in_a_end_x;   assign ae_c[1] = in_a_end_y;   assign ae_c[2] = in_a_end_z;
  assign bs_c[0] = in_b_start_x; assign bs_c[1] = in_b_start_y; assign bs_c[2] = in_b_start_z;
  assign be_c[0] = in_b_end_x;   assign be_c[1] = in_b_end_y;   assign be_c[2] = in_b_end_z;

  logic signed [CW:0] u_pipe_r [1:UVW_LAST][3];
  logic signed [CW:0] v_pipe_r [1:UVW_LAST][3];
  logic signed [CW:0] w_pipe_r [1:UVW_LAST][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u_pipe_r[1][i] <= (CW+1)'(ae_c[i]) - (CW+1)'(as_c[i]);
      v_pipe_r[1][i] <= (CW+1)'(be_c[i]) - (CW+1)'(bs_c[i]);
      w_pipe_r[1][i] <= (CW+1)'(as_c[i]) - (CW+1)'(bs_c[i]);
    end
    for (int k = 2; k <= UVW_LAST; k++) begin
      u_pipe_r[k] <= u_pipe_r[k-1];
      v_pipe_r[k] <= v_pipe_r[k-1];
      w_pipe_r[k] <= w_pipe_r[k-1];
    end
  end

  // ---- stage 2: coordinate products
  logic signed [PW-1:0] prod_r [DOT_N][3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[DOT_A][i] <= u_pipe_r[1][i] * u_pipe_r[1][i];
      prod_r[DOT_B][i] <= u_pipe_r[1][i] * v_pipe_r[1][i];
      prod_r[DOT_C][i] <= v_pipe_r[1][i] * v_pipe_r[1][i];
      prod_r[DOT_D][i] <= u_pipe_r[1][i] * w_pipe_r[1][i];
      prod_r[DOT_E][i] <= v_pipe_r[1][i] * w_pipe_r[1][i];
    end
  end

  // ---- stage 3: dot products a..e, carried on to stage 7
  logic signed [EW-1:0] dot_r [3:7][DOT_N];
  always_ff @(posedge clk) begin
    for (int j = 0; j < DOT_N; j++) begin
      dot_r[3][j] <= EW'(prod_r[j][0]) + EW'(prod_r[j][1]) + EW'(prod_r[j][2]);
    end
    for (int k = 4; k <= 7; k++) begin
      dot_r[k] <= dot_r[k-1];
    end
  end

  // ---- stages 4-5: wide products
  logic signed [2*EW-1:0] ac_w, bb_w, be_w, cd_w, ae_w, bd_w;
  ssd_mul #(.AW(EW), .BW(EW)) u_mul_ac (
    .clk(clk), .a(dot_r[3][DOT_A]), .b(dot_r[3][DOT_C]), .p(ac_w)
  );
  ssd_mul #(.AW(EW), .BW(EW)) u_mul_bb (
    .clk(clk), .a(dot_r[3][DOT_B]), .b(dot_r[3][DOT_B]), .p(bb_w)
  );
  ssd_mul #(.AW(EW), .BW(EW)) u_mul_be (
    .clk(clk), .a(dot_r[3][DOT_B]), .b(dot_r[3][DOT_E]), .p(be_w)
  );
  ssd_mul #(.AW(EW), .BW(EW)) u_mul_cd (
    .clk(clk), .a(dot_r[3][DOT_C]), .b(dot_r[3][DOT_D]), .p(cd_w)
  );
  ssd_mul #(.AW(EW), .BW(EW)) u_mul_ae (
    .clk(clk), .a(dot_r[3][DOT_A]), .b(dot_r[3][DOT_E]), .p(ae_w)
  );
  ssd_mul #(.AW(EW), .BW(EW)) u_mul_bd (
    .clk(clk), .a(dot_r[3][DOT_B]), .b(dot_r[3][DOT_D]), .p(bd_w)
  );

  // ---- stage 6: determinant and raw numerators
  logic signed [NW-1:0] det_r, sn6_r, tn6_r;
  always_ff @(posedge clk) begin
    det_r <= NW'(ac_w) - NW'(bb_w);
    sn6_r <= NW'(be_w) - NW'(cd_w);
    tn6_r <= NW'(ae_w) - NW'(bd_w);
  end

  // ---- stage 7: clamp sc, re-solve tc on the clamped edge
  logic signed [NW-1:0] sn7_nxt, sd7_nxt, tn7_nxt, td7_nxt;
  logic signed [NW-1:0] sn7_r, sd7_r, tn7_r, td7_r;
  logic signed [NW-1:0] e6, c6, b6;
  assign e6 = NW'(dot_r[6][DOT_E]);
  assign c6 = NW'(dot_r[6][DOT_C]);
  assign b6 = NW'(dot_r[6][DOT_B]);

  always_comb begin
    priority if (det_r <= 0) begin
      // parallel: fix s at 0, solve t alone
      sn7_nxt = '0;  sd7_nxt = NW'(1); tn7_nxt = e6;      td7_nxt = c6;
    end else if (sn6_r < 0) begin
      sn7_nxt = '0;  sd7_nxt = det_r;  tn7_nxt = e6;      td7_nxt = c6;
    end else if (sn6_r > det_r) begin
      sn7_nxt = det_r; sd7_nxt = det_r; tn7_nxt = e6 + b6; td7_nxt = c6;
    end else begin
      sn7_nxt = sn6_r; sd7_nxt = det_r; tn7_nxt = tn6_r;  td7_nxt = det_r;
    end
  end

  always_ff @(posedge clk) begin
    sn7_r <= sn7_nxt; sd7_r <= sd7_nxt; tn7_r <= tn7_nxt; td7_r <= td7_nxt;
  end

  // ---- stage 8: clamp tc, re-solve sc against a
  logic signed [NW-1:0] sn8_nxt, sd8_nxt, tn8_nxt, edge_num;
  logic signed [NW-1:0] sn8_r, sd8_r, tn8_r, td8_r;
  logic signed [NW-1:0] a7, b7, d7;
  logic                 t_low, t_high;
  assign a7 = NW'(dot_r[7][DOT_A]);
  assign b7 = NW'(dot_r[7][DOT_B]);
  assign d7 = NW'(dot_r[7][DOT_D]);
  assign t_low  = tn7_r < 0;
  assign t_high = tn7_r > td7_r;
  assign edge_num = t_low ? -d7 : b7 - d7;

  always_comb begin
    sn8_nxt = sn7_r;
    sd8_nxt = sd7_r;
    tn8_nxt = tn7_r;
    if (t_low) begin
      tn8_nxt = '0;
    end else if (t_high) begin
      tn8_nxt = td7_r;
    end
    if (t_low || t_high) begin
      priority if (edge_num < 0) begin
        sn8_nxt = '0;
      end else if (a7 < edge_num) begin
        sn8_nxt = sd7_r;
      end else begin
        sn8_nxt = edge_num;
        sd8_nxt = a7;
      end
    end
  end

  always_ff @(posedge clk) begin
    sn8_r <= sn8_nxt; sd8_r <= sd8_nxt; tn8_r <= tn8_nxt; td8_r <= td7_r;
  end

  // ---- stage 9: quotient guards
  logic signed [NW-1:0] sn9_r, sd9_r, tn9_r, td9_r;
  ssd_qguard_t          gs9_r, gt9_r;
  always_ff @(posedge clk) begin
    sn9_r <= sn8_r; sd9_r <= sd8_r; tn9_r <= tn8_r; td9_r <= td8_r;
    gs9_r.zero <= (sd8_r <= 0) || (sn8_r <= 0);
    gs9_r.one  <= sn8_r >= sd8_r;
    gt9_r.zero <= (td8_r <= 0) || (tn8_r <= 0);
    gt9_r.one  <= tn8_r >= td8_r;
  end

  // ---- stages 10 .. QB+10: dividers
  logic [QB:0] sc_w, tc_w;
  ssd_div #(.NW(NW), .QB(QB)) u_div_s (
    .clk(clk), .num(sn9_r), .den(sd9_r), .guard(gs9_r), .quo(sc_w)
  );
  ssd_div #(.NW(NW), .QB(QB)) u_div_t (
    .clk(clk), .num(tn9_r), .den(td9_r), .guard(gt9_r), .quo(tc_w)
  );

  // ---- output stages: w*2^Q + u*sc - v*tc, truncated toward zero
  logic signed [MW-1:0] us_r [3];
  logic signed [MW-1:0] vt_r [3];
  logic signed [CW:0]   wo_r [3];
  logic signed [TW-1:0] t_r  [3];
  logic signed [TW-1:0] adj_c [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      us_r[i] <= u_pipe_r[UVW_LAST][i] * $signed({1'b0, sc_w});
      vt_r[i] <= v_pipe_r[UVW_LAST][i] * $signed({1'b0, tc_w});
      wo_r[i] <= w_pipe_r[UVW_LAST][i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= (TW'(wo_r[i]) <<< QB) + TW'(us_r[i]) - TW'(vt_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // bias negatives so the arithmetic shift rounds toward zero
      adj_c[i] = t_r[i][TW-1] ? t_r[i] + TW'((64'd1 << QB) - 64'd1) : t_r[i];
    end
  end

  always_ff @(posedge clk) begin
    out_gap_x <= (CW+1)'(adj_c[0] >>> QB);
    out_gap_y <= (CW+1)'(adj_c[1] >>> QB);
    out_gap_z <= (CW+1)'(adj_c[2] >>> QB);
  end

endmodule
`default_nettype wire

>>> dv/tb_segment_to_segment_distance_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_segment_to_segment_distance_core;

  localparam int CW   = 24;            // coordinate width
  localparam int QF   = 24;            // quotient fraction bits
  localparam int WW   = 192;           // exact-arithmetic width, nothing wraps
  localparam int LAT  = QF + 13;       // pipeline depth, matching LAT in the core
  localparam int NRAND = 1830;
  localparam int LIMIT = 400000;       // cycles

  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [CW-1:0] crd_t;

  // stimulus shapes
  typedef enum int {
    SHP_GENERAL,
    SHP_DEGEN_A,
    SHP_DEGEN_B,
    SHP_PARALLEL,
    SHP_ANTI_PARALLEL,
    SHP_BOTH_POINTS,
    SHP_SHARED_START
  } shape_t;

  // one transaction: a_start xyz, a_end xyz, b_start xyz, b_end xyz
  typedef struct {
    crd_t p[12];
  } seg_pair_t;

  typedef struct {
    logic signed [CW:0] gx, gy, gz;
  } gap_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  crd_t drv[12];
  logic out_valid;
  logic signed [CW:0] out_gap_x, out_gap_y, out_gap_z;

  seg_pair_t pending_pairs[$];
  gap_t      gap_expected[$];
  seg_pair_t held_pair;
  int        mismatches = 0;
  int        cycles = 0;

  initial begin
    for (int i = 0; i < 12; i++) drv[i] = '0;
  end

  segment_to_segment_distance_core #(.COORD_WIDTH(CW), .QUOT_FRAC_BITS(QF)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_start_x(drv[0]), .in_a_start_y(drv[1]), .in_a_start_z(drv[2]),
    .in_a_end_x(drv[3]),   .in_a_end_y(drv[4]),   .in_a_end_z(drv[5]),
    .in_b_start_x(drv[6]), .in_b_start_y(drv[7]), .in_b_start_z(drv[8]),
    .in_b_end_x(drv[9]),   .in_b_end_y(drv[10]),  .in_b_end_z(drv[11]),
    .out_valid(out_valid), .out_gap_x(out_gap_x), .out_gap_y(out_gap_y),
    .out_gap_z(out_gap_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Closest-approach predictor, exact wide integers throughout
  // ---------------------------------------------------------------

  // floor(n * 2^QF / dn), with the guards: non-positive gives 0, n >= dn gives 1.0
  function automatic logic [63:0] param_quot(wide_t n, wide_t dn);
    logic [63:0] q;
    q = '0;
    if (dn <= 0 || n <= 0) return 64'd0;
    if (n >= dn) return 64'd1 << QF;
    for (int k = 0; k < QF; k++) begin
      n = n <<< 1;
      q = q << 1;
      if (n >= dn) begin
        n = n - dn;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic gap_t closest_gap(seg_pair_t sp);
    wide_t u[3], v[3], w[3];
    wide_t a, b, c, d, e, det, sn, sd, tn, td, num, sc, tc, t, mag;
    logic signed [CW:0] g[3];
    bit t_edge;
    gap_t r;
    for (int i = 0; i < 3; i++) begin
      u[i] = wide_t'(sp.p[3+i]) - wide_t'(sp.p[i]);
      v[i] = wide_t'(sp.p[9+i]) - wide_t'(sp.p[6+i]);
      w[i] = wide_t'(sp.p[i])   - wide_t'(sp.p[6+i]);
    end
    a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    det = a*c - b*b;
    sd = det;
    td = det;
    if (det <= 0) begin
      // parallel: pin s at 0 and solve t alone
      sn = 0; sd = 1; tn = e; td = c;
    end else begin
      sn = b*e - c*d;
      tn = a*e - b*d;
      if (sn < 0) begin
        sn = 0; tn = e; td = c;
      end else if (sn > sd) begin
        sn = sd; tn = e + b; td = c;
      end
    end
    // t clamped to an end: re-solve s on that edge
    num = 0;
    t_edge = 1'b0;
    if (tn < 0) begin
      tn = 0;
      num = -d;
      t_edge = 1'b1;
    end else if (tn > td) begin
      tn = td;
      num = b - d;
      t_edge = 1'b1;
    end
    if (t_edge) begin
      if (num < 0) sn = 0;
      else if (num > a) sn = sd;
      else begin
        sn = num; sd = a;
      end
    end
    sc = (sn == 0) ? wide_t'(0) : wide_t'(param_quot(sn, sd));
    tc = (tn == 0) ? wide_t'(0) : wide_t'(param_quot(tn, td));
    for (int i = 0; i < 3; i++) begin
      t = (w[i] <<< QF) + u[i]*sc - v[i]*tc;
      mag = (t < 0) ? -t : t;
      mag = mag >>> QF;
      if (t < 0) mag = -mag;
      g[i] = mag[CW:0];
    end
    r.gx = g[0]; r.gy = g[1]; r.gz = g[2];
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------

  function automatic crd_t rnd_crd(int span);
    if (span >= CW) return crd_t'($urandom);
    return crd_t'($signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
  endfunction

  function automatic seg_pair_t shaped_pair(shape_t shape, int span);
    seg_pair_t sp;
    crd_t off;
    for (int i = 0; i < 12; i++) sp.p[i] = rnd_crd(span);
    for (int i = 0; i < 3; i++) begin
      case (shape)
        SHP_DEGEN_A: begin
          sp.p[3+i] = sp.p[i];
        end
        SHP_DEGEN_B: begin
          sp.p[9+i] = sp.p[6+i];
        end
        SHP_PARALLEL: begin
          // B is A shifted; keep A inside a half range so the shift fits
          sp.p[i] = sp.p[i] >>> 1; sp.p[3+i] = sp.p[3+i] >>> 1;
          off = rnd_crd(span) >>> 1;
          sp.p[6+i] = sp.p[i] + off; sp.p[9+i] = sp.p[3+i] + off;
        end
        SHP_ANTI_PARALLEL: begin
          sp.p[i] = sp.p[i] >>> 1; sp.p[3+i] = sp.p[3+i] >>> 1;
          off = rnd_crd(span) >>> 1;
          sp.p[6+i] = sp.p[3+i] + off; sp.p[9+i] = sp.p[i] + off;
        end
        SHP_BOTH_POINTS: begin
          sp.p[3+i] = sp.p[i]; sp.p[9+i] = sp.p[6+i];
        end
        SHP_SHARED_START: begin
          sp.p[6+i] = sp.p[i];
        end
        default: ;
      endcase
    end
    return sp;
  endfunction

  function automatic seg_pair_t uniform_pair(crd_t val);
    seg_pair_t sp;
    for (int i = 0; i < 12; i++) sp.p[i] = val;
    return sp;
  endfunction

  initial begin
    seg_pair_t sp;
    int span;
    // directed: extremes, degenerate and parallel segments, every clamp edge
    pending_pairs.push_back(uniform_pair('0));
    pending_pairs.push_back(uniform_pair({1'b0, {(CW-1){1'b1}}}));
    pending_pairs.push_back(uniform_pair({1'b1, {(CW-1){1'b0}}}));
    sp = uniform_pair({1'b1, {(CW-1){1'b0}}});
    for (int i = 3; i < 6; i++) sp.p[i] = {1'b0, {(CW-1){1'b1}}};
    pending_pairs.push_back(sp);                      // long A, B a point at the corner
    for (int i = 6; i < 9; i++) sp.p[i] = {1'b0, {(CW-1){1'b1}}};
    pending_pairs.push_back(sp);                      // B is A reversed, from the far corner back
    sp = uniform_pair({1'b0, {(CW-1){1'b1}}});
    for (int i = 0; i < 3; i++) sp.p[3+i] = {1'b1, {(CW-1){1'b0}}};
    for (int i = 0; i < 3; i++) sp.p[9+i] = {1'b1, {(CW-1){1'b0}}};
    pending_pairs.push_back(sp);                      // identical full-range segments
    sp = uniform_pair('0);
    sp.p[3] = 24'sd4096; sp.p[7] = -24'sd4096; sp.p[10] = 24'sd4096;
    sp.p[6] = 24'sd2048; sp.p[9] = 24'sd2048; sp.p[8] = 24'sd4096; sp.p[11] = 24'sd4096;
    pending_pairs.push_back(sp);                      // crossing, interior solution
    sp.p[6] = -24'sd8192; sp.p[9] = -24'sd8192;
    pending_pairs.push_back(sp);                      // s clamps low
    sp.p[6] = 24'sd12288; sp.p[9] = 24'sd12288;
    pending_pairs.push_back(sp);                      // s clamps high
    sp.p[7] = 24'sd8192; sp.p[10] = 24'sd12288;
    pending_pairs.push_back(sp);                      // t clamps low
    sp.p[7] = -24'sd12288; sp.p[10] = -24'sd8192;
    pending_pairs.push_back(sp);                      // t clamps high
    for (int s = SHP_DEGEN_A; s <= SHP_SHARED_START; s++) begin
      pending_pairs.push_back(shaped_pair(shape_t'(s), 14));
      pending_pairs.push_back(shaped_pair(shape_t'(s), CW));
    end
    // random: mostly small geometry, some full range, a share of special shapes
    for (int n = 0; n < NRAND; n++) begin
      span = ($urandom_range(0, 3) == 0) ? CW : $urandom_range(2, 20);
      pending_pairs.push_back(shaped_pair(($urandom_range(0, 2) == 0) ?
                              shape_t'($urandom_range(SHP_DEGEN_A, SHP_SHARED_START)) :
                              SHP_GENERAL, span));
    end
  end

  // ---------------------------------------------------------------
  // Reset, driver (falling edge), monitor (rising edge)
  // ---------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // idling off for a long back-to-back stretch, else idles about 32 percent of the time
  function automatic bit sender_idles();
    if (cycles >= 800 && cycles < 1400) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  bit accepted = 1'b0;

  always @(negedge clk) begin
    if (rst_n && !(start && !accepted)) begin
      if (pending_pairs.size() > 0 && !sender_idles()) begin
        held_pair = pending_pairs.pop_front();
        for (int i = 0; i < 12; i++) drv[i] <= held_pair.p[i];
        start <= 1'b1;
      end else begin
        // idle cycle: junk on the data ports
        for (int i = 0; i < 12; i++) drv[i] <= crd_t'($urandom);
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic signed [CW:0] got, logic signed [CW:0] want);
    $display("MISMATCH %s at cycle %0d: got %0d, expected %0d", what, cycles, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    gap_t exp_gap;
    cycles <= cycles + 1;
    accepted = rst_n && start && !busy;
    // transaction accepted: predict its result from the pair held on the ports
    if (accepted) gap_expected.push_back(closest_gap(held_pair));
    if (rst_n && out_valid) begin
      if (gap_expected.size() == 0) begin
        $display("MISMATCH unexpected result at cycle %0d", cycles);
        mismatches++;
      end else begin
        exp_gap = gap_expected.pop_front();
        if (out_gap_x !== exp_gap.gx) report_mismatch("gap_x", out_gap_x, exp_gap.gx);
        if (out_gap_y !== exp_gap.gy) report_mismatch("gap_y", out_gap_y, exp_gap.gy);
        if (out_gap_z !== exp_gap.gz) report_mismatch("gap_z", out_gap_z, exp_gap.gz);
      end
    end
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("segment_to_segment_distance_core regression: fail");
      $finish;
    end
  end

  // end of run: stimulus drained, results in, then a further wait for strays
  initial begin
    wait (rst_n);
    @(posedge clk);
    while (pending_pairs.size() > 0 || start || gap_expected.size() > 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (mismatches == 0 && gap_expected.size() == 0) begin
      $display("segment_to_segment_distance_core regression: pass");
    end else begin
      if (gap_expected.size() > 0) $display("%0d results never arrived", gap_expected.size());
      $display("segment_to_segment_distance_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
src/ssd_pkg.sv
src/ssd_mul.sv
src/ssd_div.sv
src/segment_to_segment_distance_core.sv
dv/tb_segment_to_segment_distance_core.sv
